[hw/rtl/ppe_pkg.sv]
// Package for the perfect power exponent block: default width, field widths,
// sequencer states and the status group of the shared multiply unit.
// No dependencies.
package ppe_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int EXP_W           = 5;
	localparam logic [EXP_W-1:0] EXP_MAX = 5'd31;
	localparam logic [EXP_W-1:0] EXP_ONE = 5'd1;
	localparam logic [EXP_W-1:0] EXP_TWO = 5'd2;
	// multiplier digit width: one digit of the root operand per cycle
	localparam int DIG_W = 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADJ,
		S_CAND,
		S_GO,
		S_WAIT,
		S_BIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic done;
		logic over;
	} mul_sts_t;

endpackage

[hw/rtl/ppe_mul.sv]
// Digit-serial saturating multiplier shared by the root search.
// Depends on ppe_pkg (digit width, status struct).
module ppe_mul #(
	parameter int W    = ppe_pkg::VALUE_WIDTH_DEF,
	parameter int NDIG = 2,
	localparam int DW  = ppe_pkg::DIG_W,
	localparam int BW  = DW * NDIG,
	localparam int IW  = (NDIG > 1) ? $clog2(NDIG) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [W-1:0]       a,
	input  logic [BW-1:0]      b,
	input  logic [IW-1:0]      top_idx,
	input  logic [W-1:0]       limit,
	output ppe_pkg::mul_sts_t  sts,
	output logic [W-1:0]       prod
);

	logic          busy_q;
	logic          done_q;
	logic          over_q;
	logic          ov_q;
	logic [IW-1:0] idx_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  a_q;
	logic [BW-1:0] b_q;

	logic [DW-1:0]     digit;
	logic [W+DW-1:0]   pp;
	logic [W+DW:0]     sum;
	logic              ov_n;
	logic [W-1:0]      acc_n;

	// Horner step, most significant digit first: acc = acc * 2^DW + a * digit
	always_comb begin
		digit = b_q[idx_q*DW +: DW];
		pp    = (W+DW)'(a_q) * (W+DW)'(digit);
		sum   = (W+DW+1)'({acc_q, {DW{1'b0}}}) + (W+DW+1)'(pp);
		ov_n  = ov_q | (sum[W+DW:W] != '0);
		acc_n = sum[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && idx_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			idx_q <= top_idx;
			acc_q <= '0;
			ov_q  <= 1'b0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= acc_n;
			ov_q  <= ov_n;
			if (idx_q == '0) begin
				// anything above the limit counts as saturated
				over_q <= ov_n | (acc_n > limit);
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	assign sts  = '{done: done_q, over: over_q};
	assign prod = acc_q;

endmodule

[hw/rtl/perfect_power_exponent_core.sv]
// Perfect power exponent core: sequencer, root search registers and result
// register around the shared multiplier. Depends on ppe_pkg and ppe_mul.
//
// Usage: the input channel (in_valid, in_stall, value) takes one signed
// VALUE_WIDTH-bit integer per transaction. The output channel (out_valid,
// out_stall, exponent, out_of_domain) returns one transaction per input:
// the largest p in 2..31 with value equal to an integer base to the p
// (odd p only for negative values), or 1 when none exists.
// Magnitudes below two return exponent 1 with out_of_domain set. Otherwise,
// for each exponent p from 31 down, the root is built bit by bit over
// k = ceil(VALUE_WIDTH/p) bits; each bit sets a candidate and runs up to
// p-1 multiplies on the one shared multiplier, a multiply chain stopping
// as soon as the power exceeds the magnitude.
// in_stall is high from acceptance until the result is handed to the output
// register; one item is in work at a time. The output register lets a new
// item be accepted while a finished result waits under out_stall, and holds
// its payload while stalled.
// Reset clears only the sequencer and the output valid.
module perfect_power_exponent_core #(
	parameter int VALUE_WIDTH = ppe_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [VALUE_WIDTH-1:0]  value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ppe_pkg::EXP_W-1:0]      exponent,
	output logic                           out_of_domain
);

	localparam int W    = VALUE_WIDTH;
	localparam int RW   = (W + 1) / 2;           // widest root, square root case
	localparam int NDIG = (RW + ppe_pkg::DIG_W - 1) / ppe_pkg::DIG_W;
	localparam int BW   = ppe_pkg::DIG_W * NDIG;
	localparam int IW   = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int KBW  = $clog2(RW + 1);
	localparam int BTW  = $clog2(RW);
	localparam int PW   = ppe_pkg::EXP_W;
	localparam int KPW  = KBW + PW;

	ppe_pkg::state_t state_q, state_d;

	logic           neg_q;
	logic [W-1:0]   m_q;
	logic [PW-1:0]  p_q;
	logic [PW-1:0]  e_q;
	logic [PW-1:0]  best_q;
	logic           ood_q;
	logic [KBW-1:0] kb_q;
	logic [BTW-1:0] bit_q;
	logic [RW-1:0]  r_q;
	logic [RW-1:0]  c_q;
	logic [W-1:0]   acc_q;
	logic           exact_q;

	logic           out_valid_q;
	logic [PW-1:0]  exponent_q;
	logic           out_of_domain_q;

	logic [W-1:0]       mag;
	logic               mag_small;
	logic               skip_even;
	logic               need_bits;
	logic [KPW-1:0]     kp;
	logic [RW-1:0]      cand;
	logic [KBW:0]       ndig;
	logic               last_mul;
	logic               out_free;
	logic               out_load;
	logic               mul_start;
	ppe_pkg::mul_sts_t  mul_sts;
	logic [W-1:0]       mul_prod;

	// magnitude: the most negative value wraps onto its own unsigned magnitude
	assign mag       = value[W-1] ? (~value + 1'b1) : value;
	assign mag_small = (mag[W-1:1] == '0);

	// even exponents cannot give a negative value
	assign skip_even = neg_q && !p_q[0];
	// root fits in kb bits once kb * p >= W
	assign kp        = KPW'(kb_q) * KPW'(p_q);
	assign need_bits = (kp < KPW'(W));
	assign cand      = r_q | (RW'(1) << bit_q);
	assign ndig      = ((KBW+1)'(kb_q) + (KBW+1)'(ppe_pkg::DIG_W - 1)) >> $clog2(ppe_pkg::DIG_W);
	assign last_mul  = ((e_q + 1'b1) == p_q);
	assign out_free  = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ppe_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = mag_small ? ppe_pkg::S_DONE : ppe_pkg::S_ADJ;
				end
			end
			ppe_pkg::S_ADJ: begin
				if (skip_even) begin
					if (p_q == ppe_pkg::EXP_TWO) state_d = ppe_pkg::S_DONE;
				end else if (!need_bits) begin
					state_d = ppe_pkg::S_CAND;
				end
			end
			ppe_pkg::S_CAND: state_d = ppe_pkg::S_GO;
			ppe_pkg::S_GO:   state_d = ppe_pkg::S_WAIT;
			ppe_pkg::S_WAIT: begin
				if (mul_sts.done) begin
					if (mul_sts.over || last_mul) state_d = ppe_pkg::S_BIT;
					else                          state_d = ppe_pkg::S_GO;
				end
			end
			ppe_pkg::S_BIT: begin
				if (bit_q == '0) begin
					if (exact_q || p_q == ppe_pkg::EXP_TWO) state_d = ppe_pkg::S_DONE;
					else                                    state_d = ppe_pkg::S_ADJ;
				end else begin
					state_d = ppe_pkg::S_CAND;
				end
			end
			ppe_pkg::S_DONE: begin
				if (out_free) state_d = ppe_pkg::S_IDLE;
			end
			default: state_d = ppe_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = (state_q != ppe_pkg::S_IDLE);
		mul_start = (state_q == ppe_pkg::S_GO);
		out_load  = (state_q == ppe_pkg::S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppe_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// search registers
	always_ff @(posedge clk) begin
		case (state_q)
			ppe_pkg::S_IDLE: begin
				if (in_valid) begin
					neg_q  <= value[W-1];
					m_q    <= mag;
					p_q    <= ppe_pkg::EXP_MAX;
					kb_q   <= KBW'(1);
					best_q <= ppe_pkg::EXP_ONE;
					ood_q  <= mag_small;
				end
			end
			ppe_pkg::S_ADJ: begin
				if (skip_even) begin
					p_q <= p_q - 1'b1;
				end else if (need_bits) begin
					kb_q <= kb_q + 1'b1;
				end else begin
					r_q     <= '0;
					bit_q   <= BTW'(kb_q - 1'b1);
					exact_q <= 1'b0;
				end
			end
			ppe_pkg::S_CAND: begin
				// start the power chain at c to the first
				c_q   <= cand;
				acc_q <= W'(cand);
				e_q   <= ppe_pkg::EXP_ONE;
			end
			ppe_pkg::S_WAIT: begin
				if (mul_sts.done && !mul_sts.over) begin
					acc_q <= mul_prod;
					e_q   <= e_q + 1'b1;
					if (last_mul) begin
						// keep the bit: c to the p is at most the magnitude
						r_q     <= c_q;
						exact_q <= (mul_prod == m_q);
					end
				end
			end
			ppe_pkg::S_BIT: begin
				if (bit_q == '0) begin
					if (exact_q) best_q <= p_q;
					else if (p_q != ppe_pkg::EXP_TWO) p_q <= p_q - 1'b1;
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	ppe_mul #(
		.W    (W),
		.NDIG (NDIG)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (acc_q),
		.b       (BW'(c_q)),
		.top_idx (IW'(ndig - 1'b1)),
		.limit   (m_q),
		.sts     (mul_sts),
		.prod    (mul_prod)
	);

	// output register: hold under stall, accept a new result once free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			exponent_q      <= best_q;
			out_of_domain_q <= ood_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign exponent      = exponent_q;
	assign out_of_domain = out_of_domain_q;

`ifndef SYNTHESIS
	a_ood_exp_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_domain |-> exponent == ppe_pkg::EXP_ONE)
		else $error("out_of_domain result with exponent other than one");

	a_exp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> exponent != '0)
		else $error("result exponent is zero");

	a_keep_le_mag: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ppe_pkg::S_WAIT && mul_sts.done && !mul_sts.over |-> mul_prod <= m_q)
		else $error("multiplier passed a power above the magnitude");

	a_neg_odd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ppe_pkg::S_DONE && neg_q && !ood_q |-> best_q[0])
		else $error("even exponent found for a negative value");
`endif

endmodule

[bench/tb_perfect_power_exponent_core.sv]
// Self-checking bench for perfect_power_exponent_core: directed table, then random values
// with random idling on both channels, checked against an exact integer root predictor.
// Depends on ppe_pkg and the core RTL only.
module tb_perfect_power_exponent_core;

	localparam int VW             = ppe_pkg::VALUE_WIDTH_DEF;
	localparam int RANDOM_ITEMS   = 560;
	localparam int DRAIN_CYCLES   = 64;
	// the limit covers the slowest item plus a long receiver stall
	localparam int WATCHDOG_LIMIT = 30000;
	// every magnitude fits below this, so a capped power never fakes a match
	localparam logic [63:0] POW_CAP = 64'd1 << VW;

	typedef struct packed {
		logic [ppe_pkg::EXP_W-1:0] exponent;
		logic                      out_of_domain;
	} verdict_t;

	typedef struct packed {
		logic [VW-1:0] value;
		verdict_t      want;
	} pending_t;

	typedef struct packed {
		logic [VW-1:0] value;
		logic          typed;
		verdict_t      want;
	} stim_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [VW-1:0]       value;
	logic                       out_valid;
	logic                       out_stall;
	logic [ppe_pkg::EXP_W-1:0]  exponent;
	logic                       out_of_domain;

	pending_t  pending_results[$];
	stim_row_t stim_table[$];
	pending_t  oldest;
	int        mismatches  = 0;
	int        idle_cycles = 0;
	int        stall_left  = 0;
	// calm stretches: no sender gaps and no new receiver stalls
	bit        calm        = 1'b0;

	perfect_power_exponent_core #(
		.VALUE_WIDTH(VW)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.exponent     (exponent),
		.out_of_domain(out_of_domain)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// base to the power e; anything above POW_CAP collapses to POW_CAP + 1
	function automatic logic [63:0] capped_power(input logic [63:0] base, input int e);
		logic [63:0] acc;
		acc = 64'd1;
		for (int i = 0; i < e; i++) begin
			acc = acc * base;
			if (acc > POW_CAP)
				return POW_CAP + 64'd1;
		end
		return acc;
	endfunction

	// largest r with r**p <= m, for m >= 1; the root never needs more than ceil(VW/p) bits
	function automatic logic [63:0] floor_root(input logic [63:0] m, input int p);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		lo = 64'd1;
		hi = 64'd1 << ((VW + p - 1) / p);
		while (lo < hi) begin
			mid = lo + (hi - lo + 64'd1) / 2;
			if (capped_power(mid, p) <= m)
				lo = mid;
			else
				hi = mid - 64'd1;
		end
		return lo;
	endfunction

	// largest exponent 2..31 (odd only for negative values), else 1
	function automatic verdict_t predict_exponent(input logic [VW-1:0] v);
		logic [63:0] mag;
		verdict_t    r;
		bit          found;
		// sign-extend one bit so the most negative value keeps its full magnitude
		mag = v[VW-1] ? 64'(65'd0 - {{(65-VW){1'b1}}, v}) : 64'(v);
		r.exponent      = ppe_pkg::EXP_ONE;
		r.out_of_domain = (mag < 64'd2);
		found           = r.out_of_domain;
		for (int p = ppe_pkg::EXP_MAX; p >= 2 && !found; p--) begin
			if (!(v[VW-1] && (p % 2 == 0)) && capped_power(floor_root(mag, p), p) == mag) begin
				r.exponent = p[ppe_pkg::EXP_W-1:0];
				found      = 1'b1;
			end
		end
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 200);
	endfunction

	// random value: exact powers of random sign, near misses, small magnitudes, full range
	function automatic logic [VW-1:0] random_value();
		int          kind;
		int          p;
		int          near;
		bit          neg;
		logic [63:0] lim;
		logic [63:0] b;
		logic [63:0] pw;
		kind = $urandom_range(0, 99);
		if (kind < 50) begin
			p   = $urandom_range(2, ppe_pkg::EXP_MAX);
			neg = $urandom_range(0, 1);
			lim = neg ? (64'd1 << (VW - 1)) : ((64'd1 << (VW - 1)) - 64'd1);
			b   = floor_root(lim, p);
			// only a negative base reaches the top exponent
			if (b < 64'd2) begin
				neg = 1'b1;
				b   = 64'd2;
			end else begin
				b = 64'($urandom_range(2, 32'(b)));
			end
			pw = capped_power(b, p);
			// knock a fraction of them one off the exact power
			if (kind < 12) begin
				near = $urandom_range(0, 1);
				pw   = (near && pw < lim) ? pw + 64'd1 : pw - 64'd1;
			end
			return neg ? VW'(64'd0 - pw) : VW'(pw);
		end
		if (kind < 70)
			return VW'($urandom_range(0, 4000) - 2000);
		return VW'($urandom());
	endfunction

	task automatic dir_row(input logic [VW-1:0] v, input logic typed,
			input logic [ppe_pkg::EXP_W-1:0] e, input logic ood);
		stim_table.push_back('{value: v, typed: typed, want: '{exponent: e, out_of_domain: ood}});
	endtask

	// Start on a falling edge, end on the falling edge after acceptance.
	// Valid stays high into the next item when there is no gap.
	task automatic send_value(input logic [VW-1:0] v, input verdict_t want);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back('{value: v, want: want});
		@(negedge clk);
	endtask

	// Stimulus: directed table, then random values.
	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		value    = '0;
		out_stall = 1'b0;

		// value               typed  exp  ood
		dir_row(32'd0,          1'b1, 5'd1,  1'b1); // zero
		dir_row(32'd1,          1'b1, 5'd1,  1'b1); // one
		dir_row(-32'sd1,        1'b1, 5'd1,  1'b1); // minus one
		dir_row(32'd2,          1'b1, 5'd1,  1'b0); // smallest in-domain magnitude
		dir_row(-32'sd2,        1'b1, 5'd1,  1'b0);
		dir_row(32'h7FFF_FFFF,  1'b1, 5'd1,  1'b0); // largest positive, a prime
		dir_row(32'h8000_0000,  1'b1, 5'd31, 1'b0); // most negative, (-2)**31
		dir_row(32'h4000_0000,  1'b1, 5'd30, 1'b0); // 2**30
		dir_row(32'd4,          1'b0, 5'd0,  1'b0);
		dir_row(-32'sd4,        1'b0, 5'd0,  1'b0); // even power only: negative gives 1
		dir_row(-32'sd8,        1'b0, 5'd0,  1'b0);
		dir_row(32'd64,         1'b0, 5'd0,  1'b0);
		dir_row(-32'sd64,       1'b0, 5'd0,  1'b0);
		dir_row(32'd729,        1'b0, 5'd0,  1'b0);
		dir_row(-32'sd729,      1'b0, 5'd0,  1'b0);
		dir_row(32'hC000_0000,  1'b0, 5'd0,  1'b0); // -(2**30): largest odd divisor wins
		dir_row(32'd16777216,   1'b0, 5'd0,  1'b0);
		dir_row(32'd1162261467, 1'b0, 5'd0,  1'b0); // 3**19
		dir_row(-32'sd1162261467, 1'b0, 5'd0, 1'b0);
		dir_row(32'd1977326743, 1'b0, 5'd0,  1'b0); // 7**11
		dir_row(-32'sd1977326743, 1'b0, 5'd0, 1'b0);
		dir_row(32'd1000000000, 1'b0, 5'd0,  1'b0);
		dir_row(-32'sd1000000000, 1'b0, 5'd0, 1'b0);
		dir_row(32'd2147395600, 1'b0, 5'd0,  1'b0); // 46340**2, largest square
		dir_row(-32'sd2147483647, 1'b0, 5'd0, 1'b0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// the directed part runs with idling on both channels, as calm starts clear
		foreach (stim_table[i])
			send_value(stim_table[i].value,
				stim_table[i].typed ? stim_table[i].want : predict_exponent(stim_table[i].value));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			logic [VW-1:0] v;
			// flip between calm stretches and idling stretches now and then
			if ($urandom_range(0, 39) == 0)
				calm = ~calm;
			v = random_value();
			send_value(v, predict_exponent(v));
		end
		in_valid <= 1'b0;

		// drain: wait out every expected result, then a margin for strays
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: stall in bursts of random length; new bursts never start during calm stretches.
	always @(negedge clk) begin
		if (stall_left > 0)
			stall_left = stall_left - 1;
		else if (!calm && $urandom_range(0, 2) == 0)
			stall_left = pick_gap();
		out_stall <= (stall_left > 0);
	end

	// Checker: compare each output transaction with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: exponent %0d out_of_domain %0b",
					exponent, out_of_domain);
				mismatches++;
			end else begin
				oldest = pending_results.pop_front();
				if (exponent !== oldest.want.exponent) begin
					$error("exponent for value %0d: expected %0d, got %0d",
						$signed(oldest.value), oldest.want.exponent, exponent);
					mismatches++;
				end
				if (out_of_domain !== oldest.want.out_of_domain) begin
					$error("out_of_domain for value %0d: expected %0b, got %0b",
						$signed(oldest.value), oldest.want.out_of_domain, out_of_domain);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transaction on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
